### rtl/gcc_pkg.sv
// Package for the graph clustering coefficient block.
// Holds sizes, action codes and the sequencer state type; depends on nothing.
package gcc_pkg;

  localparam int unsigned MaxNodes = 256;
  localparam int unsigned MaxEdges = 4096;

  localparam int unsigned NodeW  = 8;   // node number
  localparam int unsigned CntW   = 9;   // node count, 1..256
  localparam int unsigned FieldW = 13;  // index, value, offset, degree
  localparam int unsigned EdgeAw = 12;  // neighbour list address
  localparam int unsigned CoefW  = 17;  // unsigned Q1.16
  localparam int unsigned LinkW  = 15;  // saturated link count
  localparam int unsigned LinksW = 23;  // full link count of one node
  localparam int unsigned DenW   = 24;  // d * (d - 1)
  localparam int unsigned RemW   = 41;  // dividend of the shared divider
  localparam int unsigned SumW   = 25;  // sum of node coefficients
  localparam int unsigned ResW   = CoefW + LinkW + FieldW;

  localparam logic [CoefW-1:0] QOne    = 17'd65536;
  localparam logic [LinkW-1:0] LinkSat = 15'd32767;

  typedef enum logic [1:0] {
    ACT_WR_ROW  = 2'd0,
    ACT_WR_NBR  = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_READ    = 2'd3
  } action_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FS, ST_FE, ST_FC, ST_FL, ST_FV,
    ST_PS, ST_PE, ST_PC, ST_PL, ST_PA, ST_PR, ST_PQ, ST_PQV,
    ST_PD, ST_PN, ST_DIV, ST_PW,
    ST_MN, ST_MW,
    ST_RV, ST_EMIT
  } state_e;

endpackage

### rtl/gcc_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; used for every store of the clustering coefficient block.
module gcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/graph_clustering_coefficient.sv
// Local clustering coefficient engine for a graph held in compressed sparse row form.
// Depends on gcc_pkg and gcc_ram.
//
// Write words load the row start table (action 0) and the neighbour list (action 1);
// an out-of-range write is dropped and sets the sticky error flag. A compute word
// (action 2) walks the graph twice with one shared sequencer. The first pass builds
// each node's adjacency row in a 256-bit register and writes it to the adjacency RAM,
// so no clearing pass is needed. The second pass counts linked neighbour pairs p < q
// and, for each node with two or more neighbours, divides 2*links*65536 + d(d-1)/2 by
// d(d-1) in a restoring divider that retires one quotient bit per cycle. The same
// divider forms the rounded mean of the node values. The compute word answers with
// the mean (kind 0). A read word (action 3) presents one node's coefficient, link
// count and degree (kind 1). The block takes no new word until the current one has
// handed its result to the output register; the configuration register (node count,
// clamped to 1..256) is written only while the block is idle.
module graph_clustering_coefficient (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gcc_pkg::CntW-1:0]     cfg_node_count_i,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic [gcc_pkg::FieldW-1:0]   entry_index_i,
  input  logic [gcc_pkg::FieldW-1:0]   entry_value_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         result_kind_o,
  output logic [gcc_pkg::CoefW-1:0]    coefficient_value_o,
  output logic [gcc_pkg::LinkW-1:0]    linked_pairs_o,
  output logic [gcc_pkg::FieldW-1:0]   neighbour_count_o,
  output logic                         input_error_o
);
  import gcc_pkg::*;

  state_e state_q, state_d;

  logic [CntW-1:0]    node_count_q;
  logic [CntW-1:0]    n_used;
  logic               acc;
  logic               err_q;

  logic [CntW-1:0]    k_q;
  logic [FieldW-1:0]  s_q, e_q, d_q, p_q, q_q;
  logic [NodeW-1:0]   a_q;
  logic [MaxNodes-1:0] row_q;
  logic [LinksW-1:0]  links_q;
  logic [DenW-1:0]    den_q;
  logic [RemW-1:0]    rem_q, dsh_q;
  logic [CoefW-1:0]   quot_q;
  logic [4:0]         cnt_q;
  logic               mean_mode_q;
  logic [SumW-1:0]    sum_q;
  logic               rd_ok_q;

  logic               st_kind_q;
  logic [CoefW-1:0]   st_coef_q;
  logic [LinkW-1:0]   st_links_q;
  logic [FieldW-1:0]  st_deg_q;

  logic               out_valid_q, out_kind_q, out_err_q;
  logic [CoefW-1:0]   out_coef_q;
  logic [LinkW-1:0]   out_links_q;
  logic [FieldW-1:0]  out_deg_q;

  // RAM ports
  logic               rs_we, nl_we, adj_we, res_we;
  logic [CntW-1:0]    rs_raddr;
  logic [FieldW-1:0]  rs_rdata;
  logic [EdgeAw-1:0]  nl_raddr;
  logic [NodeW-1:0]   nl_rdata;
  logic [MaxNodes-1:0] adj_rdata;
  logic [ResW-1:0]    res_rdata;

  logic               last_node, slot_free, k_lt_n;
  logic [CoefW-1:0]   coef_clamped;
  logic [LinkW-1:0]   links_sat;
  logic [2*FieldW-1:0] den_full;
  logic               wr_row_ok, wr_nbr_ok;

  assign n_used = (node_count_q == '0) ? CntW'(1) :
                  (node_count_q > CntW'(MaxNodes)) ? CntW'(MaxNodes) : node_count_q;
  assign acc        = in_valid_i && !in_stall_o;
  assign last_node  = (k_q == n_used - CntW'(1));
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign k_lt_n     = (entry_index_i < FieldW'(n_used));
  assign wr_row_ok  = (entry_index_i <= FieldW'(MaxNodes)) &&
                      (entry_value_i <= FieldW'(MaxEdges));
  assign wr_nbr_ok  = (entry_index_i < FieldW'(MaxEdges)) &&
                      (entry_value_i < FieldW'(MaxNodes));
  assign coef_clamped = (quot_q > QOne) ? QOne : quot_q;
  assign links_sat    = (links_q > LinksW'(LinkSat)) ? LinkSat : links_q[LinkW-1:0];
  assign den_full     = d_q * (d_q - FieldW'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && action_i == ACT_COMPUTE) state_d = ST_FS;
        else if (acc && action_i == ACT_READ) state_d = ST_RV;
      end
      ST_FS:  state_d = ST_FE;
      ST_FE:  state_d = ST_FC;
      ST_FC:  state_d = ST_FL;
      ST_FL: begin
        if (p_q < e_q) state_d = ST_FV;
        else if (last_node) state_d = ST_PS;
        else state_d = ST_FS;
      end
      ST_FV:  state_d = ST_FL;
      ST_PS:  state_d = ST_PE;
      ST_PE:  state_d = ST_PC;
      ST_PC:  state_d = ST_PL;
      ST_PL: begin
        if (d_q < FieldW'(2) || p_q >= e_q) state_d = ST_PD;
        else state_d = ST_PA;
      end
      ST_PA:  state_d = ST_PR;
      ST_PR:  state_d = ST_PQ;
      ST_PQ:  state_d = (q_q < e_q) ? ST_PQV : ST_PL;
      ST_PQV: state_d = ST_PQ;
      ST_PD:  state_d = (d_q < FieldW'(2)) ? ST_PW : ST_PN;
      ST_PN:  state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) state_d = mean_mode_q ? ST_MW : ST_PW;
      end
      ST_PW:  state_d = last_node ? ST_MN : ST_PS;
      ST_MN:  state_d = ST_DIV;
      ST_MW:  state_d = ST_EMIT;
      ST_RV:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs and RAM addressing.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    rs_we      = acc && action_i == ACT_WR_ROW && wr_row_ok;
    nl_we      = acc && action_i == ACT_WR_NBR && wr_nbr_ok;
    adj_we     = (state_q == ST_FL) && !(p_q < e_q);
    res_we     = (state_q == ST_PW);
    rs_raddr   = k_q;
    nl_raddr   = p_q[EdgeAw-1:0];
    case (state_q)
      ST_FE, ST_PE: rs_raddr = k_q + CntW'(1);
      ST_PQ:        nl_raddr = q_q[EdgeAw-1:0];
      default:      ;
    endcase
  end

  gcc_ram #(.Width(FieldW), .Depth(MaxNodes + 1)) u_rs_ram (
    .clk_i, .we_i(rs_we), .waddr_i(entry_index_i[CntW-1:0]),
    .wdata_i(entry_value_i), .raddr_i(rs_raddr), .rdata_o(rs_rdata)
  );

  gcc_ram #(.Width(NodeW), .Depth(MaxEdges)) u_nl_ram (
    .clk_i, .we_i(nl_we), .waddr_i(entry_index_i[EdgeAw-1:0]),
    .wdata_i(entry_value_i[NodeW-1:0]), .raddr_i(nl_raddr), .rdata_o(nl_rdata)
  );

  gcc_ram #(.Width(MaxNodes), .Depth(MaxNodes)) u_adj_ram (
    .clk_i, .we_i(adj_we), .waddr_i(k_q[NodeW-1:0]),
    .wdata_i(row_q), .raddr_i(a_q), .rdata_o(adj_rdata)
  );

  gcc_ram #(.Width(ResW), .Depth(MaxNodes)) u_res_ram (
    .clk_i, .we_i(res_we), .waddr_i(k_q[NodeW-1:0]),
    .wdata_i({coef_clamped, links_sat, d_q}),
    .raddr_i(entry_index_i[NodeW-1:0]), .rdata_o(res_rdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= CntW'(1);
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) node_count_q <= cfg_node_count_i;
      if (acc && action_i == ACT_WR_ROW && !wr_row_ok) err_q <= 1'b1;
      if (acc && action_i == ACT_WR_NBR && !wr_nbr_ok) err_q <= 1'b1;
      if (acc && action_i == ACT_READ && !k_lt_n) err_q <= 1'b1;
      if (state_q == ST_FC && rs_rdata < s_q) err_q <= 1'b1;
      if (state_q == ST_FV && {1'b0, nl_rdata} >= n_used) err_q <= 1'b1;
      if (state_q == ST_EMIT && slot_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        k_q     <= '0;
        sum_q   <= '0;
        rd_ok_q <= k_lt_n;
      end
      ST_FE, ST_PE: s_q <= rs_rdata;
      ST_FC: begin
        e_q   <= rs_rdata;
        p_q   <= s_q;
        row_q <= '0;
      end
      ST_FL: begin
        if (!(p_q < e_q)) k_q <= last_node ? '0 : k_q + CntW'(1);
      end
      ST_FV: begin
        if ({1'b0, nl_rdata} < n_used) row_q[nl_rdata] <= 1'b1;
        p_q <= p_q + FieldW'(1);
      end
      ST_PC: begin
        e_q     <= rs_rdata;
        d_q     <= (rs_rdata >= s_q) ? rs_rdata - s_q : '0;
        p_q     <= s_q;
        links_q <= '0;
      end
      ST_PA: begin
        a_q <= nl_rdata;
        q_q <= p_q + FieldW'(1);
      end
      ST_PQ: begin
        if (!(q_q < e_q)) p_q <= p_q + FieldW'(1);
      end
      ST_PQV: begin
        if ({1'b0, a_q} < n_used && adj_rdata[nl_rdata]) links_q <= links_q + LinksW'(1);
        q_q <= q_q + FieldW'(1);
      end
      ST_PD: begin
        den_q  <= den_full[DenW-1:0];
        quot_q <= '0;
      end
      ST_PN: begin
        rem_q       <= RemW'({links_q, 17'd0}) + RemW'(den_q >> 1);
        dsh_q       <= RemW'({den_q, 16'd0});
        cnt_q       <= 5'd16;
        quot_q      <= '0;
        mean_mode_q <= 1'b0;
      end
      ST_DIV: begin
        // One restoring step: one quotient bit per cycle, most significant first.
        if (rem_q >= dsh_q) begin
          rem_q  <= rem_q - dsh_q;
          quot_q <= {quot_q[CoefW-2:0], 1'b1};
        end else begin
          quot_q <= {quot_q[CoefW-2:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
        cnt_q <= cnt_q - 5'd1;
      end
      ST_PW: begin
        sum_q <= sum_q + SumW'(coef_clamped);
        k_q   <= last_node ? '0 : k_q + CntW'(1);
      end
      ST_MN: begin
        rem_q       <= RemW'(sum_q) + RemW'(n_used >> 1);
        dsh_q       <= RemW'({n_used, 16'd0});
        cnt_q       <= 5'd16;
        quot_q      <= '0;
        mean_mode_q <= 1'b1;
      end
      ST_MW: begin
        st_kind_q  <= 1'b0;
        st_coef_q  <= quot_q;
        st_links_q <= '0;
        st_deg_q   <= '0;
      end
      ST_RV: begin
        st_kind_q  <= 1'b1;
        st_coef_q  <= rd_ok_q ? res_rdata[ResW-1 -: CoefW] : '0;
        st_links_q <= rd_ok_q ? res_rdata[FieldW +: LinkW] : '0;
        st_deg_q   <= rd_ok_q ? res_rdata[FieldW-1:0] : '0;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_kind_q  <= st_kind_q;
          out_coef_q  <= st_coef_q;
          out_links_q <= st_links_q;
          out_deg_q   <= st_deg_q;
          out_err_q   <= err_q;
        end
      end
      default: ;
    endcase
  end

  // The node count may only change while no word is being worked on.
  assign cfg_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = out_kind_q;
  assign coefficient_value_o = out_coef_q;
  assign linked_pairs_o      = out_links_q;
  assign neighbour_count_o   = out_deg_q;
  assign input_error_o       = out_err_q;

endmodule

### rtl/gcc_checker.sv
// Port-level checks for the graph clustering coefficient block.
// Depends on gcc_pkg; bound to graph_clustering_coefficient below.
module gcc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       result_kind_o,
  input logic [gcc_pkg::CoefW-1:0]  coefficient_value_o,
  input logic [gcc_pkg::LinkW-1:0]  linked_pairs_o,
  input logic [gcc_pkg::FieldW-1:0] neighbour_count_o,
  input logic                       input_error_o
);
  import gcc_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(coefficient_value_o))
    else $error("stalled result word changed");

  a_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o |-> linked_pairs_o == '0 && neighbour_count_o == '0)
    else $error("mean word carries node figures");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> coefficient_value_o <= QOne)
    else $error("coefficient above one");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && input_error_o |=> input_error_o)
    else $error("error flag cleared");

endmodule

bind graph_clustering_coefficient gcc_checker u_gcc_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .result_kind_o,
  .coefficient_value_o, .linked_pairs_o, .neighbour_count_o, .input_error_o
);
